>>> design/slh_pkg.sv
// Shared types and constants for the subchannel lag histogram.
// Used by slh_cell and subchannel_lag_histogram_unit; depends on nothing.
package slh_pkg;

   // Field widths
   localparam int CNT_W   = 20;
   localparam int DELTA_W = 22;

   // Saturation and clamp limits
   localparam logic [CNT_W-1:0]          CNT_MAX      = 20'hFFFFF;
   localparam logic signed [DELTA_W-1:0] DELTA_LO     = 22'sh200000;
   localparam logic signed [DELTA_W-1:0] DELTA_HI     = 22'sh1FFFFF;
   localparam logic [6:0]                DISTINCT_MAX = 7'd127;

   // Address arithmetic
   localparam logic [7:0] LBA_OFFSET     = 8'd150;
   localparam logic [6:0] SECS_PER_MIN   = 7'd60;
   localparam logic [6:0] FRAMES_PER_SEC = 7'd75;
   localparam logic [3:0] ADR_POSITION   = 4'd1;

   // Report limits and register reset values
   localparam int         MAX_RESULTS      = 64;
   localparam logic [6:0] SPREAD_MAX_RESET = 7'd8;

   // Request codes
   localparam logic [1:0] REQ_FRAME  = 2'd0;
   localparam logic [1:0] REQ_REPORT = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // Verdict codes
   localparam logic [1:0] VERDICT_NONE   = 2'd0;
   localparam logic [1:0] VERDICT_SPREAD = 2'd1;
   localparam logic [1:0] VERDICT_NO_LAG = 2'd2;
   localparam logic [1:0] VERDICT_LAG    = 2'd3;

   // Register indexes
   localparam logic CSR_BASE_LBA   = 1'b0;
   localparam logic CSR_SPREAD_MAX = 1'b1;

   // Command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_CLEAR,
      CMD_SORT_EVEN,
      CMD_SORT_ODD,
      CMD_ROTATE
   } cmd_type;

   // Where a cell sits in the chain
   typedef struct packed {
      logic odd;
      logic head;
      logic tail;
   } cell_pos_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_INJECT,
      ST_WALK,
      ST_SORT,
      ST_JUDGE,
      ST_EMIT,
      ST_RESTORE
   } state_type;

endpackage

>>> design/subchannel_lag_histogram_unit.sv
// Top level of the subchannel lag histogram: sequencer, totals and the bucket chain.
// Depends on slh_pkg and slh_cell.
//
//  Channel  Ports                         Direction  Moves
//  req      req_valid/req_ready + fields  in         one frame, report or clear request
//  rsp      rsp_valid/rsp_ready + fields  out        one bucket line of a report
//  csr      csr_we/csr_index/csr_wdata    in         register write, no handshake
//
// A frame that is CRC-bad or not a position frame is handled in ST_IDLE; a position
// frame goes on through ST_CALC, ST_INJECT and ST_WALK, its probe walking the chain
// one cell a cycle. A report on a non-empty table takes BUCKETS odd-even sort phases,
// a verdict step, then emits one result per cycle while rsp_ready is high and adds the
// rotations that bring the chain back, BUCKETS rotations in all. Synchronous reset
// clears all counters and bucket valid bits; a clear request does the same. rsp_ready
// low holds the report; no request is taken until the current one has finished.
module subchannel_lag_histogram_unit #(
   parameter int BUCKETS   = 64,
   parameter int SLOT_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_type,
   input  logic                              req_crc_ok,
   input  logic [3:0]                        req_adr_mode,
   input  logic [6:0]                        req_abs_minute,
   input  logic [5:0]                        req_abs_second,
   input  logic [6:0]                        req_abs_frame,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_verdict,
   output logic signed [slh_pkg::DELTA_W-1:0] rsp_entry_delta,
   output logic [slh_pkg::CNT_W-1:0]         rsp_entry_count,
   output logic [6:0]                        rsp_distinct_count,
   output logic                              rsp_table_overflowed,
   output logic [slh_pkg::CNT_W-1:0]         rsp_good_count,
   output logic [slh_pkg::CNT_W-1:0]         rsp_bad_count,
   output logic [slh_pkg::CNT_W-1:0]         rsp_nonpos_count,
   output logic [slh_pkg::CNT_W-1:0]         rsp_slot_count,
   output logic                              rsp_last,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [slh_pkg::CNT_W-1:0]         csr_wdata
);
   import slh_pkg::*;

   localparam int SEQ_W = $clog2(BUCKETS);
   localparam int UW    = $clog2(BUCKETS + 1);
   localparam int SW    = (SLOT_BITS > CNT_W) ? SLOT_BITS : CNT_W;
   localparam int SUM_W = SW + 1;
   localparam int DW    = SUM_W + 2;

   typedef struct packed {
      logic               valid;
      logic [DELTA_W-1:0] delta;
      logic [CNT_W-1:0]   count;
      logic [SEQ_W-1:0]   seq;
   } entry_type;

   typedef struct packed {
      logic               active;
      logic               found;
      logic               claimed;
      logic [DELTA_W-1:0] delta;
      logic [SEQ_W-1:0]   seq;
   } probe_type;

   localparam int ENT_W = $bits(entry_type);
   localparam int PRB_W = $bits(probe_type);

   // Registers
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     base_lba_ff;
   logic [6:0]           spread_max_ff;
   logic [UW-1:0]        used_ff, used_in;
   logic                 overflow_ff, overflow_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]     good_ff, good_in, bad_ff, bad_in, nonpos_ff, nonpos_in;
   logic [UW-1:0]        step_ff, step_in;
   logic                 empty_ff, empty_in;
   logic [1:0]           verdict_ff, verdict_in;
   logic [12:0]          mins_ff, mins_in;
   logic [6:0]           frame_ff, frame_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [DELTA_W-1:0]   delta_ff, delta_in;

   // Chain wiring
   cmd_type              cell_cmd;
   probe_type            inject;
   logic [ENT_W-1:0]     ent [BUCKETS];
   logic [PRB_W-1:0]     prb [BUCKETS+1];
   entry_type            head;
   probe_type            tail_probe;

   // Datapath helpers
   logic [CNT_W-1:0]     lba_prod;
   logic signed [DW-1:0] diff;
   logic [UW-1:0]        emit_total;
   logic [UW-1:0]        step_next;
   logic                 emit_last;
   logic [SW-1:0]        slot_wide;

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v != CNT_MAX) ? v + 1'b1 : CNT_MAX;
   endfunction

   assign head       = entry_type'(ent[0]);
   assign tail_probe = probe_type'(prb[BUCKETS]);
   assign prb[0]     = inject;

   // Bucket chain
   for (genvar i = 0; i < BUCKETS; i++) begin : g_cell
      cell_pos_type pos;
      assign pos = '{odd: 1'(i % 2), head: (i == 0), tail: (i == BUCKETS - 1)};
      slh_cell #(.SEQ_W(SEQ_W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd),
         .pos         (pos),
         .left_entry  (ent[(i + BUCKETS - 1) % BUCKETS]),
         .right_entry (ent[(i + 1) % BUCKETS]),
         .entry       (ent[i]),
         .probe_in    (prb[i]),
         .probe_out   (prb[i+1])
      );
   end

   // Frame delta: own LBA minus (base + slot), in a width that cannot wrap
   assign lba_prod = CNT_W'(mins_ff) * CNT_W'(FRAMES_PER_SEC);
   assign diff     = DW'(lba_prod) + DW'(frame_ff) - DW'(LBA_OFFSET) - DW'(sum_ff);

   // Report bookkeeping
   assign emit_total = (int'(used_ff) < MAX_RESULTS) ? used_ff : UW'(MAX_RESULTS);
   assign step_next  = step_ff + 1'b1;
   assign emit_last  = empty_ff || (step_next == emit_total);

   // Sequencer: next state, totals and chain commands
   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      overflow_in = overflow_ff;
      slot_in     = slot_ff;
      good_in     = good_ff;
      bad_in      = bad_ff;
      nonpos_in   = nonpos_ff;
      step_in     = step_ff;
      empty_in    = empty_ff;
      verdict_in  = verdict_ff;
      mins_in     = mins_ff;
      frame_in    = frame_ff;
      sum_in      = sum_ff;
      delta_in    = delta_ff;
      cell_cmd    = CMD_HOLD;
      inject      = '0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_type)
                  REQ_FRAME: begin
                     mins_in  = 13'(req_abs_minute) * 13'(SECS_PER_MIN) + 13'(req_abs_second);
                     frame_in = req_abs_frame;
                     sum_in   = SUM_W'(base_lba_ff) + SUM_W'(slot_ff);
                     if (slot_ff != '1) slot_in = slot_ff + 1'b1;
                     if (!req_crc_ok) begin
                        bad_in = sat_inc(bad_ff);
                     end else begin
                        good_in = sat_inc(good_ff);
                        if (req_adr_mode != ADR_POSITION) nonpos_in = sat_inc(nonpos_ff);
                        else state_in = ST_CALC;
                     end
                  end
                  REQ_REPORT: begin
                     step_in  = '0;
                     empty_in = (used_ff == '0);
                     state_in = (used_ff == '0) ? ST_EMIT : ST_SORT;
                  end
                  REQ_CLEAR: begin
                     cell_cmd    = CMD_CLEAR;
                     used_in     = '0;
                     overflow_in = 1'b0;
                     slot_in     = '0;
                     good_in     = '0;
                     bad_in      = '0;
                     nonpos_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_CALC: begin
            // clamp to the 22-bit delta range
            if (diff < DW'(DELTA_LO))      delta_in = DELTA_LO;
            else if (diff > DW'(DELTA_HI)) delta_in = DELTA_HI;
            else                           delta_in = diff[DELTA_W-1:0];
            state_in = ST_INJECT;
         end
         ST_INJECT: begin
            inject.active = 1'b1;
            inject.delta  = delta_ff;
            inject.seq    = used_ff[SEQ_W-1:0];
            state_in      = ST_WALK;
         end
         ST_WALK: begin
            if (tail_probe.active) begin
               if (tail_probe.claimed) used_in = used_ff + 1'b1;
               if (!tail_probe.found) overflow_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SORT: begin
            cell_cmd = step_ff[0] ? CMD_SORT_ODD : CMD_SORT_EVEN;
            step_in  = step_next;
            if (step_ff == UW'(BUCKETS - 1)) begin
               step_in  = '0;
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            if (overflow_ff || (int'(used_ff) > int'(spread_max_ff)))
               verdict_in = VERDICT_SPREAD;
            else if (head.delta == '0)
               verdict_in = VERDICT_NO_LAG;
            else
               verdict_in = VERDICT_LAG;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (empty_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cell_cmd = CMD_ROTATE;
                  step_in  = step_next;
                  if (emit_last)
                     state_in = (step_next == UW'(BUCKETS)) ? ST_IDLE : ST_RESTORE;
               end
            end
         end
         ST_RESTORE: begin
            // finish a full turn so free cells sit at the tail again
            cell_cmd = CMD_ROTATE;
            step_in  = step_next;
            if (step_next == UW'(BUCKETS)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         used_ff     <= '0;
         overflow_ff <= 1'b0;
         slot_ff     <= '0;
         good_ff     <= '0;
         bad_ff      <= '0;
         nonpos_ff   <= '0;
         step_ff     <= '0;
         empty_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         overflow_ff <= overflow_in;
         slot_ff     <= slot_in;
         good_ff     <= good_in;
         bad_ff      <= bad_in;
         nonpos_ff   <= nonpos_in;
         step_ff     <= step_in;
         empty_ff    <= empty_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      mins_ff    <= mins_in;
      frame_ff   <= frame_in;
      sum_ff     <= sum_in;
      delta_ff   <= delta_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_lba_ff   <= '0;
         spread_max_ff <= SPREAD_MAX_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_BASE_LBA)   base_lba_ff   <= csr_wdata;
         if (csr_index == CSR_SPREAD_MAX) spread_max_ff <= csr_wdata[6:0];
      end
   end

   // Result fields
   assign slot_wide = SW'(slot_ff);

   assign rsp_verdict          = empty_ff ? VERDICT_NONE : verdict_ff;
   assign rsp_entry_delta      = empty_ff ? '0 : head.delta;
   assign rsp_entry_count      = empty_ff ? '0 : head.count;
   assign rsp_distinct_count   = (int'(used_ff) > int'(DISTINCT_MAX)) ? DISTINCT_MAX
                                                                     : 7'(used_ff);
   assign rsp_table_overflowed = overflow_ff;
   assign rsp_good_count       = good_ff;
   assign rsp_bad_count        = bad_ff;
   assign rsp_nonpos_count     = nonpos_ff;
   assign rsp_slot_count       = (slot_wide > SW'(CNT_MAX)) ? CNT_MAX : slot_wide[CNT_W-1:0];
   assign rsp_last             = emit_last;

endmodule

>>> design/slh_cell.sv
// One histogram bucket cell: holds a delta, its count and its first-seen rank.
// Depends on slh_pkg. Probes pass cell to cell; sort and rotate trade with neighbors.
module slh_cell #(
   parameter int SEQ_W = 6,
   localparam int ENT_W = 1 + slh_pkg::DELTA_W + slh_pkg::CNT_W + SEQ_W,
   localparam int PRB_W = 3 + slh_pkg::DELTA_W + SEQ_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  slh_pkg::cmd_type      cmd,
   input  slh_pkg::cell_pos_type pos,
   input  logic [ENT_W-1:0]      left_entry,
   input  logic [ENT_W-1:0]      right_entry,
   output logic [ENT_W-1:0]      entry,
   input  logic [PRB_W-1:0]      probe_in,
   output logic [PRB_W-1:0]      probe_out
);
   import slh_pkg::*;

   typedef struct packed {
      logic               valid;
      logic [DELTA_W-1:0] delta;
      logic [CNT_W-1:0]   count;
      logic [SEQ_W-1:0]   seq;
   } entry_type;

   typedef struct packed {
      logic               active;
      logic               found;
      logic               claimed;
      logic [DELTA_W-1:0] delta;
      logic [SEQ_W-1:0]   seq;
   } probe_type;

   entry_type entry_ff, entry_in, lft, rgt;
   probe_type probe_ff, probe_in_c, prb_nxt;
   logic      pair_left;

   // Right-hand entry belongs ahead: left empty, larger count, or equal count seen earlier
   function automatic logic out_of_order(entry_type l, entry_type r);
      return r.valid && (!l.valid || (r.count > l.count) ||
                         ((r.count == l.count) && (r.seq < l.seq)));
   endfunction

   assign lft        = entry_type'(left_entry);
   assign rgt        = entry_type'(right_entry);
   assign probe_in_c = probe_type'(probe_in);
   assign pair_left  = (pos.odd == (cmd == CMD_SORT_ODD));

   // Next entry and outgoing probe
   always_comb begin
      entry_in = entry_ff;
      prb_nxt  = probe_in_c;
      case (cmd)
         CMD_CLEAR: begin
            entry_in.valid = 1'b0;
            entry_in.count = '0;
            prb_nxt.active = 1'b0;
         end
         CMD_SORT_EVEN, CMD_SORT_ODD: begin
            if (pair_left) begin
               if (!pos.tail && out_of_order(entry_ff, rgt)) entry_in = rgt;
            end else begin
               if (!pos.head && out_of_order(lft, entry_ff)) entry_in = lft;
            end
         end
         CMD_ROTATE: begin
            entry_in = rgt;
         end
         default: begin
            // serve a passing probe: match first, else claim the first free cell
            if (probe_in_c.active && !probe_in_c.found) begin
               if (entry_ff.valid && (entry_ff.delta == probe_in_c.delta)) begin
                  if (entry_ff.count != CNT_MAX) entry_in.count = entry_ff.count + 1'b1;
                  prb_nxt.found = 1'b1;
               end else if (!entry_ff.valid) begin
                  entry_in.valid  = 1'b1;
                  entry_in.delta  = probe_in_c.delta;
                  entry_in.count  = CNT_W'(1);
                  entry_in.seq    = probe_in_c.seq;
                  prb_nxt.found   = 1'b1;
                  prb_nxt.claimed = 1'b1;
               end
            end
         end
      endcase
   end

   // Cell registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid  <= 1'b0;
         entry_ff.count  <= '0;
         probe_ff.active <= 1'b0;
      end else begin
         entry_ff.valid  <= entry_in.valid;
         entry_ff.count  <= entry_in.count;
         probe_ff.active <= prb_nxt.active;
      end
      entry_ff.delta   <= entry_in.delta;
      entry_ff.seq     <= entry_in.seq;
      probe_ff.found   <= prb_nxt.found;
      probe_ff.claimed <= prb_nxt.claimed;
      probe_ff.delta   <= prb_nxt.delta;
      probe_ff.seq     <= prb_nxt.seq;
   end

   assign entry     = entry_ff;
   assign probe_out = probe_ff;

endmodule
